FILE: design/hsmp_pkg.sv
// package for the half-size max pool block: sizes, register indexes and byte compare
`default_nettype none

package hsmp_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int LINE_DEPTH  = MAX_WIDTH / 2;
    localparam int LINE_ADDR_W = $clog2(LINE_DEPTH);
    localparam int COL_W       = $clog2(MAX_WIDTH);

    localparam int BYTE_W      = 8;
    localparam int PIXEL_W     = 4 * BYTE_W;
    localparam int WIDTH_REG_W = 13;
    localparam int HEIGHT_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd480;
    localparam logic                   ALPHA_RESET  = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_ALPHA_ENABLE = 2'd2
    } cfg_index_t;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // per-byte unsigned maximum of two packed pixels
    function automatic pixel_t byte_max(input pixel_t a, input pixel_t b);
        pixel_t r;
        r = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (a[i*BYTE_W +: BYTE_W] > b[i*BYTE_W +: BYTE_W])
                r[i*BYTE_W +: BYTE_W] = a[i*BYTE_W +: BYTE_W];
            else
                r[i*BYTE_W +: BYTE_W] = b[i*BYTE_W +: BYTE_W];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/hsmp_if.sv
// channel interfaces: input pixel items and pooled pixel items
`default_nettype none

interface hsmp_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [hsmp_pkg::BYTE_W-1:0] red;
    logic [hsmp_pkg::BYTE_W-1:0] green;
    logic [hsmp_pkg::BYTE_W-1:0] blue;
    logic [hsmp_pkg::BYTE_W-1:0] alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface

interface hsmp_pooled_if;
    logic                      valid;
    logic                      ready;
    logic [hsmp_pkg::BYTE_W-1:0] out_red;
    logic [hsmp_pkg::BYTE_W-1:0] out_green;
    logic [hsmp_pkg::BYTE_W-1:0] out_blue;
    logic [hsmp_pkg::BYTE_W-1:0] out_alpha;
    logic                      last_of_image;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, output last_of_image, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_alpha, input last_of_image, output ready);
endinterface

`default_nettype wire

FILE: design/hsmp_ram.sv
// generic simple dual-port ram, one write port, one registered read port
`default_nettype none

module hsmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/image_half_size_max_pool_core.sv
// top level: 2x2 stride-2 max pooling over a raster pixel stream
//
//  channel   dir  handshake          payload
//  pixel     in   valid/ready        red, green, blue, alpha (8b each)
//  pooled    out  valid/ready        out_red/green/blue/alpha (8b), last_of_image
//  cfg       in   cfg_write          cfg_index (2b), cfg_data (16b)
//
//  one pixel item accepted per cycle unless stalled; a pooled item leaves in the
//  cycle after the pixel that closes its 2x2 block, set by the registered line ram
//  read; the ram (2048 x 32) keeps pair maxima of the last even row; no clearing pass
//  reset clears counters and loads width 640, height 480, alpha enabled
//  a pooled item held by a stalled consumer drops pixel ready until it is taken;
//  pixel ready follows pooled ready in the same cycle, so a taken item frees the input
`default_nettype none

module image_half_size_max_pool_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    hsmp_pixel_if.sink                            pixel,
    hsmp_pooled_if.source                         pooled,
    input  wire logic                             cfg_write,
    input  wire logic [hsmp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hsmp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int WW  = hsmp_pkg::WIDTH_REG_W;
    localparam int HW  = hsmp_pkg::HEIGHT_W;
    localparam int CW  = hsmp_pkg::COL_W;
    localparam int AW  = hsmp_pkg::LINE_ADDR_W;

    // configuration registers
    logic [WW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic          alpha_en_reg;

    // position and pair state
    logic [CW-1:0]            col_reg, col_next;
    logic [HW-1:0]            row_reg, row_next;
    hsmp_pkg::pixel_t         pair_reg, pair_next;

    // result stage, paired with the line ram read data
    logic                     s2_valid_reg, s2_valid_next;
    hsmp_pkg::pixel_t         s2_pair_reg;
    logic                     s2_last_reg;

    logic [WW-1:0]            width_eff;
    logic [HW-1:0]            height_eff;
    logic [WW-1:0]            col_inc;
    logic [HW:0]              row_inc;
    logic                     in_range;
    logic                     accept;
    logic                     last_flag;
    hsmp_pkg::pixel_t         pix;
    hsmp_pkg::pixel_t         pair_max;
    hsmp_pkg::pixel_t         line_rdata;
    hsmp_pkg::pixel_t         block_max;
    logic [AW-1:0]            line_addr;
    logic                     ram_we;
    logic                     ram_re;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= hsmp_pkg::WIDTH_RESET;
            height_reg   <= hsmp_pkg::HEIGHT_RESET;
            alpha_en_reg <= hsmp_pkg::ALPHA_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hsmp_pkg::CFG_IMAGE_WIDTH:  width_reg    <= cfg_data[WW-1:0];
                hsmp_pkg::CFG_IMAGE_HEIGHT: height_reg   <= cfg_data[HW-1:0];
                hsmp_pkg::CFG_ALPHA_ENABLE: alpha_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp sizes into their legal range
    always_comb
    begin
        priority if (width_reg < WW'(2))
            width_eff = WW'(2);
        else if (width_reg > WW'(hsmp_pkg::MAX_WIDTH))
            width_eff = WW'(hsmp_pkg::MAX_WIDTH);
        else
            width_eff = width_reg;

        if (height_reg < HW'(2))
            height_eff = HW'(2);
        else
            height_eff = height_reg;
    end

    // ---------------- input side ----------------
    // input stalls only when a result is held and the consumer is not taking it
    assign pixel.ready = !s2_valid_reg || pooled.ready;
    assign accept      = pixel.valid && pixel.ready;

    assign pix = {(alpha_en_reg ? pixel.alpha : 8'd0), pixel.blue, pixel.green, pixel.red};
    assign pair_max = hsmp_pkg::byte_max(pair_reg, pix);

    assign col_inc  = WW'(col_reg) + WW'(1);
    assign row_inc  = {1'b0, row_reg} + (HW+1)'(1);
    assign in_range = (WW'(col_reg) < width_eff) && (row_reg < height_eff);

    // pair index into the line ram
    assign line_addr = col_reg[CW-1:1];

    // odd column closes a horizontal pair: even rows store it, odd rows pool it
    assign ram_we = accept && in_range && col_reg[0] && !row_reg[0];
    assign ram_re = accept && in_range && col_reg[0] &&  row_reg[0];

    // final block: last full odd row, last full pair
    assign last_flag = (row_reg == ({height_eff[HW-1:1], 1'b0} - HW'(1)))
                    && (CW'(line_addr) == (width_eff[WW-1:1] - CW'(1)));

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        pair_next = pair_reg;
        if (accept)
        begin
            if (in_range)
            begin
                if (col_reg[0])
                    pair_next = pair_max;
                else
                    pair_next = pix;
            end
            // out-of-range position ends its row, or the image
            if (col_inc >= width_eff)
            begin
                col_next = '0;
                if (row_inc >= {1'b0, height_eff})
                    row_next = '0;
                else
                    row_next = row_inc[HW-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
    end

    // ---------------- line store ----------------
    hsmp_ram #(
        .WIDTH (hsmp_pkg::PIXEL_W),
        .DEPTH (hsmp_pkg::LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (line_addr),
        .wdata (pair_max),
        .re    (ram_re),
        .raddr (line_addr),
        .rdata (line_rdata)
    );

    // ---------------- result stage ----------------
    always_comb
    begin
        priority if (ram_re)
            s2_valid_next = 1'b1;
        else if (pooled.ready)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s2_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            s2_pair_reg <= pair_max;
            s2_last_reg <= last_flag;
        end
    end

    // line ram data and pair stay put while the result waits
    assign block_max = hsmp_pkg::byte_max(line_rdata, s2_pair_reg);

    assign pooled.valid         = s2_valid_reg;
    assign pooled.out_red       = block_max[7:0];
    assign pooled.out_green     = block_max[15:8];
    assign pooled.out_blue      = block_max[23:16];
    assign pooled.out_alpha     = block_max[31:24];
    assign pooled.last_of_image = s2_last_reg;

    // ---------------- checks ----------------
    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("line ram written and read in one cycle");

    a_read_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (!s2_valid_reg || pooled.ready))
        else $error("line ram read while result stage is held");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s2_valid_reg) |-> $past(ram_re))
        else $error("result raised without a line ram read");

    a_held_result_keeps_data: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !pooled.ready) |=> $stable(line_rdata) && $stable(s2_pair_reg))
        else $error("held result lost its operands");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// testbench for image_half_size_max_pool_core: 2x2 max pool scoreboard and channel drivers
`timescale 1ns / 1ps

typedef struct packed {
    logic [hsmp_pkg::BYTE_W-1:0] red;
    logic [hsmp_pkg::BYTE_W-1:0] green;
    logic [hsmp_pkg::BYTE_W-1:0] blue;
    logic [hsmp_pkg::BYTE_W-1:0] alpha;
    logic                        last;
} pooled_item_t;

class pool_scoreboard;
    logic [hsmp_pkg::WIDTH_REG_W-1:0] width_reg;
    logic [hsmp_pkg::HEIGHT_W-1:0]    height_reg;
    logic                             alpha_on;
    int unsigned                      col_pos;
    int unsigned                      row_pos;
    hsmp_pkg::pixel_t                 pair_max;
    hsmp_pkg::pixel_t                 line_mem [hsmp_pkg::LINE_DEPTH];
    pooled_item_t                     pending [$];
    int                               mismatches;

    function new();
        width_reg  = hsmp_pkg::WIDTH_RESET;
        height_reg = hsmp_pkg::HEIGHT_RESET;
        alpha_on   = hsmp_pkg::ALPHA_RESET;
        col_pos    = 0;
        row_pos    = 0;
        pair_max   = '0;
        mismatches = 0;
    endfunction

    function int unsigned clamp_width(int unsigned w);
        if (w < 2)
            return 2;
        if (w > hsmp_pkg::MAX_WIDTH)
            return hsmp_pkg::MAX_WIDTH;
        return w;
    endfunction

    function int unsigned clamp_height(int unsigned h);
        return (h < 2) ? 2 : h;
    endfunction

    function int unsigned active_width();
        return clamp_width(width_reg);
    endfunction

    function int unsigned active_height();
        return clamp_height(height_reg);
    endfunction

    function bit at_image_start();
        return (col_pos == 0) && (row_pos == 0);
    endfunction

    function void write_reg(hsmp_pkg::cfg_index_t idx,
                            logic [hsmp_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            hsmp_pkg::CFG_IMAGE_WIDTH:  width_reg  = data[hsmp_pkg::WIDTH_REG_W-1:0];
            hsmp_pkg::CFG_IMAGE_HEIGHT: height_reg = data[hsmp_pkg::HEIGHT_W-1:0];
            hsmp_pkg::CFG_ALPHA_ENABLE: alpha_on   = data[0];
            default: ;
        endcase
    endfunction

    // unsigned maximum taken byte by byte
    static function hsmp_pkg::pixel_t larger_bytes(hsmp_pkg::pixel_t a, hsmp_pkg::pixel_t b);
        hsmp_pkg::pixel_t r;
        for (int i = 0; i < 4; i++)
        begin
            r[i*hsmp_pkg::BYTE_W +: hsmp_pkg::BYTE_W] =
                (a[i*hsmp_pkg::BYTE_W +: hsmp_pkg::BYTE_W] >
                 b[i*hsmp_pkg::BYTE_W +: hsmp_pkg::BYTE_W]) ?
                a[i*hsmp_pkg::BYTE_W +: hsmp_pkg::BYTE_W] :
                b[i*hsmp_pkg::BYTE_W +: hsmp_pkg::BYTE_W];
        end
        return r;
    endfunction

    function void note_pixel(logic [hsmp_pkg::BYTE_W-1:0] r, logic [hsmp_pkg::BYTE_W-1:0] g,
                             logic [hsmp_pkg::BYTE_W-1:0] b, logic [hsmp_pkg::BYTE_W-1:0] a);
        int unsigned      w;
        int unsigned      h;
        int unsigned      slot;
        hsmp_pkg::pixel_t px;
        hsmp_pkg::pixel_t blk;
        pooled_item_t     item;
        w  = active_width();
        h  = active_height();
        px = {alpha_on ? a : 8'd0, b, g, r};
        if (col_pos < w && row_pos < h)
        begin
            if (col_pos % 2 == 0)
                pair_max = px;
            else
            begin
                slot     = (col_pos / 2) % hsmp_pkg::LINE_DEPTH;
                pair_max = larger_bytes(pair_max, px);
                if (row_pos % 2 == 0)
                    line_mem[slot] = pair_max;
                else
                begin
                    blk        = larger_bytes(line_mem[slot], pair_max);
                    item.red   = blk[0*hsmp_pkg::BYTE_W +: hsmp_pkg::BYTE_W];
                    item.green = blk[1*hsmp_pkg::BYTE_W +: hsmp_pkg::BYTE_W];
                    item.blue  = blk[2*hsmp_pkg::BYTE_W +: hsmp_pkg::BYTE_W];
                    item.alpha = blk[3*hsmp_pkg::BYTE_W +: hsmp_pkg::BYTE_W];
                    item.last  = (row_pos == 2 * (h / 2) - 1) && (col_pos / 2 == w / 2 - 1);
                    pending.push_back(item);
                end
            end
        end
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endfunction

    function void check_pooled(pooled_item_t got);
        pooled_item_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("pooled item with nothing expected: r=%0d g=%0d b=%0d a=%0d last=%0b",
                         got.red, got.green, got.blue, got.alpha, got.last);
            return;
        end
        want = pending.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("pooled item mismatch: expected r=%0d g=%0d b=%0d a=%0d last=%0b, %s",
                         want.red, want.green, want.blue, want.alpha, want.last,
                         $sformatf("got r=%0d g=%0d b=%0d a=%0d last=%0b",
                                   got.red, got.green, got.blue, got.alpha, got.last));
        end
    endfunction
endclass

module testbench;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [hsmp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [hsmp_pkg::CFG_DATA_W-1:0]  cfg_data;

    hsmp_pixel_if  pixel_ch ();
    hsmp_pooled_if pooled_ch ();

    image_half_size_max_pool_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch),
        .pooled    (pooled_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pool_scoreboard sb;

    // idle pattern state: a quiet flag gives stretches with no gaps at all
    bit in_quiet;
    bit out_quiet;
    int stall_left;
    int pixels_fed;

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #10_000_000;
        $display("image_half_size_max_pool_core verification failed");
        $finish;
    end

    // gap length: mostly none or short, now and then long
    function automatic int idle_length(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // byte source with extra weight on the extremes
    function automatic logic [hsmp_pkg::BYTE_W-1:0] rand_byte();
        int          r;
        logic [31:0] x;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'd0;
        if (r < 16)
            return 8'd255;
        x = $urandom_range(0, 255);
        return x[hsmp_pkg::BYTE_W-1:0];
    endfunction

    // sink side: ready changes at the falling edge, random stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                pooled_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                pooled_ch.ready = 1'b1;
                stall_left = idle_length(out_quiet);
                if ($urandom_range(0, 199) == 0)
                    out_quiet = !out_quiet;
            end
        end
    end

    // result monitor: one pooled item per rising edge with valid and ready
    always @(posedge clk)
    begin
        pooled_item_t got;
        if (rst_n && pooled_ch.valid === 1'b1 && pooled_ch.ready === 1'b1)
        begin
            got.red   = pooled_ch.out_red;
            got.green = pooled_ch.out_green;
            got.blue  = pooled_ch.out_blue;
            got.alpha = pooled_ch.out_alpha;
            got.last  = pooled_ch.last_of_image;
            sb.check_pooled(got);
        end
    end

    // one pixel item: optional gap, then hold until accepted
    task automatic send_pixel(logic [hsmp_pkg::BYTE_W-1:0] r, logic [hsmp_pkg::BYTE_W-1:0] g,
                              logic [hsmp_pkg::BYTE_W-1:0] b, logic [hsmp_pkg::BYTE_W-1:0] a);
        int gap;
        gap = idle_length(in_quiet);
        if ($urandom_range(0, 199) == 0)
            in_quiet = !in_quiet;
        if (gap > 0)
        begin
            pixel_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_ch.valid = 1'b1;
        pixel_ch.red   = r;
        pixel_ch.green = g;
        pixel_ch.blue  = b;
        pixel_ch.alpha = a;
        @(posedge clk);
        while (pixel_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_pixel(r, g, b, a);
        @(negedge clk);
    endtask

    // count > 0: that many pixels; count == 0: until the image wraps
    task automatic feed_pixels(int count);
        int n;
        n = 0;
        do
        begin
            send_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte());
            n++;
        end
        while (count > 0 ? n < count : !sb.at_image_start());
        pixels_fed += n;
    endtask

    // wait for every pooled item, then let the line ram read settle
    task automatic drain_pipeline();
        pixel_ch.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(hsmp_pkg::cfg_index_t idx,
                                  logic [hsmp_pkg::CFG_DATA_W-1:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        sb.write_reg(idx, data);
    endtask

    // registers change only with the block drained
    task automatic set_image(logic [hsmp_pkg::CFG_DATA_W-1:0] w_data,
                             logic [hsmp_pkg::CFG_DATA_W-1:0] h_data,
                             logic [hsmp_pkg::CFG_DATA_W-1:0] a_data);
        drain_pipeline();
        write_register(hsmp_pkg::CFG_IMAGE_WIDTH, w_data);
        write_register(hsmp_pkg::CFG_IMAGE_HEIGHT, h_data);
        write_register(hsmp_pkg::CFG_ALPHA_ENABLE, a_data);
    endtask

    // random geometry; mid-image the size only shrinks, so no odd row ever
    // reads a line entry that no even row wrote
    task automatic random_setup();
        int unsigned                     cur_w;
        int unsigned                     cur_h;
        int unsigned                     w;
        int unsigned                     h;
        int                              r;
        bit                              mid;
        logic [31:0]                     rnd;
        logic [hsmp_pkg::CFG_DATA_W-1:0] w_data;
        logic [hsmp_pkg::CFG_DATA_W-1:0] h_data;
        logic [hsmp_pkg::CFG_DATA_W-1:0] a_data;
        mid   = !sb.at_image_start();
        cur_w = sb.active_width();
        cur_h = sb.active_height();
        r = $urandom_range(0, 99);
        if (r < 8)
            w = $urandom_range(0, 1);
        else if (r < 80)
            w = $urandom_range(2, 12);
        else if (r < 95)
            w = $urandom_range(13, 40);
        else
            w = $urandom_range(41, 300);
        if (mid && sb.clamp_width(w) > cur_w)
            w = $urandom_range(2, cur_w);
        r = $urandom_range(0, 99);
        if (r < 8)
            h = $urandom_range(0, 1);
        else if (r < 85 || w > 40)
            h = $urandom_range(2, (w > 40) ? 3 : 8);
        else
            h = $urandom_range(9, 24);
        if (mid && sb.clamp_height(h) > cur_h)
            h = $urandom_range(2, cur_h);
        // upper data bits beyond the register width are don't-care
        w_data = w[hsmp_pkg::CFG_DATA_W-1:0];
        if ($urandom_range(0, 19) == 0)
        begin
            rnd = $urandom;
            w_data[hsmp_pkg::CFG_DATA_W-1:hsmp_pkg::WIDTH_REG_W] =
                rnd[hsmp_pkg::CFG_DATA_W-hsmp_pkg::WIDTH_REG_W-1:0];
        end
        h_data = h[hsmp_pkg::CFG_DATA_W-1:0];
        rnd    = $urandom_range(0, 1);
        if ($urandom_range(0, 9) == 0)
            rnd = $urandom;
        a_data = rnd[hsmp_pkg::CFG_DATA_W-1:0];
        set_image(w_data, h_data, a_data);
    endtask

    // main sequence
    initial
    begin
        int unsigned                 col;
        int unsigned                 row;
        int unsigned                 blk;
        int unsigned                 pos;
        logic [hsmp_pkg::BYTE_W-1:0] v [4];
        sb             = new();
        in_quiet       = 1'b0;
        out_quiet      = 1'b0;
        stall_left     = 0;
        pixels_fed     = 0;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = hsmp_pkg::CFG_IMAGE_WIDTH;
        cfg_data       = '0;
        pixel_ch.valid = 1'b0;
        pixel_ch.red   = '0;
        pixel_ch.green = '0;
        pixel_ch.blue  = '0;
        pixel_ch.alpha = '0;
        pooled_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset geometry 640 wide: first even row plus one block of the odd row
        feed_pixels(642);
        // shrink mid-row: the column lies past nothing yet, pooling goes on
        set_image(16'd4, 16'd4, 16'd1);
        feed_pixels(0);

        // directed 4x4: block of zeros, block of 255, each channel peaking at
        // its own position, and near-max ties
        for (int i = 0; i < 16; i++)
        begin
            col = i % 4;
            row = i / 4;
            blk = (row / 2) * 2 + col / 2;
            pos = (row % 2) * 2 + col % 2;
            for (int ch = 0; ch < 4; ch++)
            begin
                case (blk)
                    0: v[ch] = 8'd0;
                    1: v[ch] = 8'd255;
                    2: v[ch] = (pos == ch) ? 8'(200 + ch) : 8'(ch * 10 + pos);
                    default: v[ch] = (pos == 3 - ch) ? 8'd255 : 8'd254;
                endcase
            end
            send_pixel(v[0], v[1], v[2], v[3]);
        end
        pixels_fed += 16;

        // alpha disabled: full alpha input must come out as zero
        set_image(16'd2, 16'd2, 16'd0);
        repeat (4) send_pixel(8'd255, 8'd255, 8'd255, 8'd255);

        // width and height below range act as 2
        set_image(16'd1, 16'd0, 16'd1);
        repeat (4) send_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte());

        // odd width: last column dropped
        set_image(16'd3, 16'd2, 16'd1);
        repeat (6) send_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte());
        pixels_fed += 14;

        // width above range and tallest height, stopped early in the first row
        set_image(16'h1FFF, 16'hFFFF, 16'd0);
        feed_pixels(40);
        // shrink below the column counter: the pending pixel ends its row
        set_image(16'd2, 16'd2, 16'd1);
        feed_pixels(0);

        // shrink below both counters: the pending pixel ends the image
        set_image(16'd6, 16'd6, 16'd1);
        feed_pixels(15);
        set_image(16'd2, 16'd2, 16'd1);
        feed_pixels(0);

        // random phases, mostly whole images, some cut short
        while (pixels_fed < 1250)
        begin
            random_setup();
            if ($urandom_range(0, 99) < 80)
                feed_pixels(0);
            else
                feed_pixels($urandom_range(1, sb.active_width() * sb.active_height()));
        end

        drain_pipeline();
        repeat (10) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("image_half_size_max_pool_core verification clean");
        else
            $display("image_half_size_max_pool_core verification failed");
        $finish;
    end

endmodule
